### rtl/cxd_pkg.sv
package cxd_pkg;

   localparam int unsigned MAX_HEX_DIGITS = 8;
   localparam int unsigned DIGIT_COUNT_W  = 4;
   localparam int unsigned SIZE_W         = 32;

   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   typedef enum logic [2:0] {
      PH_LENGTH = 3'd0,
      PH_EXT    = 3'd1,
      PH_DATA   = 3'd2,
      PH_TRAIL  = 3'd3,
      PH_DONE   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_RUNNING  = 2'd0,
      ST_COMPLETE = 2'd1,
      ST_ERROR    = 2'd2
   } status_type;

   typedef struct packed {
      logic       end_of_stream;
      logic [7:0] in_byte;
   } item_type;

   typedef struct packed {
      logic [1:0] status;
      logic       is_payload;
      logic       out_valid;
      logic [7:0] out_byte;
   } result_type;

endpackage

### rtl/cxd_in_reg.sv
module cxd_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cxd_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output cxd_pkg::item_type out_item
);
   import cxd_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

### rtl/cxd_core.sv
module cxd_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wen,
   input  logic                csr_wdata,
   input  logic                in_valid,
   output logic                in_ready,
   input  cxd_pkg::item_type   in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output cxd_pkg::result_type out_result
);
   import cxd_pkg::*;

   phase_type                  phase_ff, phase_in;
   logic [DIGIT_COUNT_W-1:0]   digit_count_ff, digit_count_in;
   logic [SIZE_W-1:0]          chunk_size_ff, chunk_size_in;
   logic [SIZE_W-1:0]          bytes_taken_ff, bytes_taken_in;
   logic                       cr_seen_ff, cr_seen_in;
   logic                       done_ff, done_in;
   logic                       error_ff, error_in;
   logic                       strip_ff;
   logic                       out_valid_ff;
   result_type                 result_ff, result_in;
   logic                       fire;
   logic                       emit;
   logic                       payload;
   logic                       is_hex;
   logic [3:0]                 hex_val;
   logic                       is_cr;
   logic                       is_lf;
   logic [7:0]                 b;

   assign in_ready   = !out_valid_ff || out_ready;
   assign fire       = in_valid && in_ready;
   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;
   assign b          = in_item.in_byte;
   assign is_cr      = (b == CHAR_CR);
   assign is_lf      = (b == CHAR_LF);

   always_comb begin
      is_hex  = 1'b1;
      hex_val = '0;
      priority if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         hex_val = 4'(b - CHAR_ZERO);
      end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_F) begin
         hex_val = 4'(b - CHAR_LOWER_A + 8'd10);
      end else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) begin
         hex_val = 4'(b - CHAR_UPPER_A + 8'd10);
      end else begin
         is_hex = 1'b0;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      digit_count_in = digit_count_ff;
      chunk_size_in  = chunk_size_ff;
      bytes_taken_in = bytes_taken_ff;
      cr_seen_in     = cr_seen_ff;
      done_in        = done_ff;
      error_in       = error_ff;
      emit           = 1'b0;
      payload        = 1'b0;
      if (!error_ff) begin
         unique case (phase_ff)
            PH_LENGTH: begin
               if (is_hex) begin
                  if (digit_count_ff >= DIGIT_COUNT_W'(MAX_HEX_DIGITS)) begin
                     error_in = 1'b1;
                  end else begin
                     chunk_size_in  = {chunk_size_ff[SIZE_W-5:0], hex_val};
                     digit_count_in = digit_count_ff + 1'b1;
                     emit           = 1'b1;
                  end
               end else if (digit_count_ff == '0) begin
                  error_in = 1'b1;
               end else begin
                  bytes_taken_in = '0;
                  emit           = 1'b1;
                  if (chunk_size_ff == '0) begin
                     phase_in   = PH_DONE;
                     cr_seen_in = 1'b0;
                     done_in    = 1'b1;
                  end else begin
                     phase_in   = PH_EXT;
                     cr_seen_in = is_cr;
                  end
               end
            end
            PH_EXT, PH_TRAIL: begin
               emit = 1'b1;
               if (cr_seen_ff && is_lf) begin
                  cr_seen_in = 1'b0;
                  if (phase_ff == PH_EXT) begin
                     bytes_taken_in = '0;
                     phase_in       = PH_DATA;
                  end else begin
                     digit_count_in = '0;
                     chunk_size_in  = '0;
                     phase_in       = PH_LENGTH;
                  end
               end else begin
                  cr_seen_in = is_cr;
               end
            end
            PH_DATA: begin
               emit = 1'b1;
               if (bytes_taken_ff < chunk_size_ff) begin
                  bytes_taken_in = bytes_taken_ff + 1'b1;
                  payload        = 1'b1;
               end else begin
                  phase_in   = PH_TRAIL;
                  cr_seen_in = is_cr;
               end
            end
            PH_DONE: begin
               done_in = 1'b1;
               emit    = 1'b1;
            end
            default: begin
            end
         endcase
         if (emit && !payload && strip_ff) begin
            emit = 1'b0;
         end
         if (error_in) begin
            emit = 1'b0;
         end
         if (!error_in && in_item.end_of_stream && !done_in) begin
            error_in = 1'b1;
         end
      end
      result_in.out_byte   = emit ? b : 8'd0;
      result_in.out_valid  = emit;
      result_in.is_payload = emit && payload;
      result_in.status     = error_in ? ST_ERROR : (done_in ? ST_COMPLETE : ST_RUNNING);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LENGTH;
         digit_count_ff <= '0;
         chunk_size_ff  <= '0;
         bytes_taken_ff <= '0;
         cr_seen_ff     <= 1'b0;
         done_ff        <= 1'b0;
         error_ff       <= 1'b0;
         strip_ff       <= 1'b1;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_wen) begin
            strip_ff <= csr_wdata;
         end
         if (fire) begin
            phase_ff       <= phase_in;
            digit_count_ff <= digit_count_in;
            chunk_size_ff  <= chunk_size_in;
            bytes_taken_ff <= bytes_taken_in;
            cr_seen_ff     <= cr_seen_in;
            done_ff        <= done_in;
            error_ff       <= error_in;
         end
         if (in_ready) begin
            out_valid_ff <= in_valid;
         end
      end
      if (fire) begin
         result_ff <= result_in;
      end
   end

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      error_ff |=> error_ff)
      else $error("error flag cleared without reset");

   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> phase_ff == PH_DONE)
      else $error("done set outside end phase");

   a_data_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> bytes_taken_ff <= chunk_size_ff)
      else $error("payload count beyond chunk size");

   a_payload_valid: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && result_ff.is_payload |-> result_ff.out_valid)
      else $error("payload marked on dropped byte");

   a_error_silent: assert property (@(posedge clock) disable iff (reset)
      fire && error_ff |=> !result_ff.out_valid && result_ff.status == ST_ERROR)
      else $error("byte emitted after error");

endmodule

### rtl/chunked_transfer_decoder.sv
// A taken byte is held in the input register, then decoded into the core's result register, from which it can transfer.
// Throughput: one byte per cycle without rsp stalls; length/payload state updates in a single pass.
// Backpressure on rsp holds both registers; req_tready drops once both hold a byte.
// Reset (synchronous, active high) clears all decode state and sets strip_framing to 1.
module chunked_transfer_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic        csr_wdata,    // strip_framing
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte
   input  logic        req_tlast,    // end_of_stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [7:0] out_byte, [8] out_valid, [10:9] status
   output logic        rsp_tuser     // is_payload
);
   import cxd_pkg::*;

   item_type   req_item;
   item_type   stage_item;
   logic       stage_valid;
   logic       stage_ready;
   result_type result;

   assign req_item.in_byte       = req_tdata;
   assign req_item.end_of_stream = req_tlast;

   cxd_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (stage_valid),
      .out_ready (stage_ready),
      .out_item  (stage_item)
   );

   cxd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .in_valid   (stage_valid),
      .in_ready   (stage_ready),
      .in_item    (stage_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {5'd0, result.status, result.out_valid, result.out_byte};
   assign rsp_tuser = result.is_payload;

endmodule
